>>> rtl/core/scgw_pkg.sv
// Shared types and constants for the scaled glyph column writer.
// No dependencies; scgw_if, scgw_cfg, scgw_seq and the top module import this package.
package scgw_pkg;

  localparam int MAX_COLUMNS = 128;
  localparam int MAX_LINES   = 8;
  localparam int MAX_SCALE   = 4;

  localparam int BUF_DEPTH = 256;
  localparam int ADDR_W    = 8;
  localparam int WORD_W    = 32;
  localparam int BYTE_W    = 8;
  localparam int LANES     = WORD_W / BYTE_W;
  localparam int LANE_W    = 2;

  localparam int ACTION_W = 2;
  localparam int REQ_W    = 8;
  localparam int COL_W    = 8;
  localparam int LINE_W   = 3;
  localparam int LINES_W  = 4;
  localparam int SCALE_W  = 3;
  localparam int ROW_W    = 2;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;

  typedef enum logic [ACTION_W-1:0] {
    ACT_SET_CURSOR = 2'd0,
    ACT_GLYPH_COL  = 2'd1,
    ACT_READ_WORD  = 2'd2,
    ACT_NONE       = 2'd3
  } action_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DISPLAY_COLUMNS = 1'b0,
    REG_DISPLAY_LINES   = 1'b1
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ROW_RD,
    ST_ROW_WR,
    ST_RD_WAIT,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic [COL_W-1:0]   cols;
    logic [LINES_W-1:0] lines;
  } dims_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [WORD_W-1:0] wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

endpackage

>>> rtl/core/scgw_if.sv
// Valid/ready channel interfaces for input items and result items.
// Depends on scgw_pkg for field widths.
interface scgw_in_if import scgw_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [ACTION_W-1:0] action;
  logic [REQ_W-1:0]    line_request;
  logic [REQ_W-1:0]    column_request;
  logic [WORD_W-1:0]   column_bits;
  logic [SCALE_W-1:0]  glyph_scale;
  logic                last_column;
  logic [ADDR_W-1:0]   read_index;

  modport source (output valid, action, line_request, column_request, column_bits,
                  glyph_scale, last_column, read_index, input ready);
  modport sink (input valid, action, line_request, column_request, column_bits,
                glyph_scale, last_column, read_index, output ready);
endinterface

interface scgw_out_if import scgw_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              cursor_exact;
  logic              column_placed;
  logic [WORD_W-1:0] read_word;
  logic [LINE_W-1:0] current_line;
  logic [COL_W-1:0]  current_column;

  modport source (output valid, cursor_exact, column_placed, read_word, current_line,
                  current_column, input ready);
  modport sink (input valid, cursor_exact, column_placed, read_word, current_line,
                current_column, output ready);
endinterface

>>> rtl/core/scgw_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module scgw_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/core/scgw_cfg.sv
// Display geometry registers, clamped to the supported range on write.
// Depends on scgw_pkg.
module scgw_cfg import scgw_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output dims_t                 dims
);

  dims_t              dims_r;
  dims_t              dims_nxt;
  logic [COL_W-1:0]   cols_clamp;
  logic [LINES_W-1:0] lines_clamp;

  always_comb begin
    priority if ({cfg_wdata[COL_W-1:2], 2'b00} > COL_W'(MAX_COLUMNS)) begin
      cols_clamp = COL_W'(MAX_COLUMNS);
    end else if (cfg_wdata[COL_W-1:2] == '0) begin
      cols_clamp = COL_W'(4);
    end else begin
      cols_clamp = {cfg_wdata[COL_W-1:2], 2'b00};
    end
    priority if (cfg_wdata[LINES_W-1:0] > LINES_W'(MAX_LINES)) begin
      lines_clamp = LINES_W'(MAX_LINES);
    end else if (cfg_wdata[LINES_W-1:0] == '0) begin
      lines_clamp = LINES_W'(1);
    end else begin
      lines_clamp = cfg_wdata[LINES_W-1:0];
    end
  end

  always_comb begin
    dims_nxt = dims_r;
    if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_DISPLAY_COLUMNS: dims_nxt.cols  = cols_clamp;
        REG_DISPLAY_LINES:   dims_nxt.lines = lines_clamp;
        default:             dims_nxt = dims_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dims_r.cols  <= COL_W'(MAX_COLUMNS);
      dims_r.lines <= LINES_W'(MAX_LINES);
    end else begin
      dims_r <= dims_nxt;
    end
  end

  assign dims = dims_r;

endmodule

>>> rtl/core/scgw_seq.sv
// Item sequencer: cursor, per-row read-modify-write of the frame buffer, result register.
// Depends on scgw_pkg and scgw_if; drives the frame buffer RAM through mem_req_t.
module scgw_seq import scgw_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  dims_t             dims,
  scgw_in_if.sink           in_ch,
  scgw_out_if.source        out_ch,
  output mem_req_t          mem_req,
  input  logic [WORD_W-1:0] mem_rdata
);

  state_t             state_r, state_nxt;
  logic [LINE_W-1:0]  cur_line_r, cur_line_nxt;
  logic [COL_W-1:0]   cur_col_r, cur_col_nxt;
  logic [WORD_W-1:0]  bits_r, bits_nxt;
  logic [SCALE_W-1:0] scale_r, scale_nxt;
  logic               last_r, last_nxt;
  logic [ROW_W-1:0]   h_r, h_nxt;
  logic [SCALE_W-1:0] gap_left_r, gap_left_nxt;
  logic               in_gap_r, in_gap_nxt;
  logic               exact_r, exact_nxt;
  logic               placed_r, placed_nxt;
  logic [WORD_W-1:0]  word_r, word_nxt;
  logic [ADDR_W-1:0]  wr_addr_r, wr_addr_nxt;
  logic [ADDR_W-1:0]  clr_addr_r, clr_addr_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic               out_exact_r, out_placed_r;
  logic [WORD_W-1:0]  out_word_r;
  logic [LINE_W-1:0]  out_line_r;
  logic [COL_W-1:0]   out_col_r;
  logic               out_load;

  logic [SCALE_W-1:0] scale_in;
  logic [LINES_W-1:0] row_line;
  logic               row_in;
  logic [ADDR_W:0]    idx_full;
  logic [BYTE_W-1:0]  row_byte;
  logic [WORD_W-1:0]  rd_word;
  logic [WORD_W-1:0]  merged;
  logic               row_last;
  logic [COL_W-1:0]   col_plus;
  logic [SCALE_W-1:0] gaps_avail;
  logic               advance;

  assign row_line = LINES_W'(cur_line_r) + LINES_W'(h_r);
  assign row_in   = row_line < dims.lines;
  assign idx_full = (ADDR_W+1)'(cur_col_r[COL_W-1:2])
                  + (ADDR_W+1)'(row_line[LINE_W-1:0]) * (ADDR_W+1)'(dims.cols[COL_W-1:2]);
  assign row_byte = bits_r[{h_r, 3'b000} +: BYTE_W];
  assign rd_word  = mem_rdata;
  assign row_last = SCALE_W'(h_r) == scale_r - SCALE_W'(1);
  assign col_plus = cur_col_r + COL_W'(1);
  assign gaps_avail = in_gap_r ? gap_left_r : (last_r ? scale_r : '0);

  always_comb begin
    priority if (in_ch.glyph_scale == '0) begin
      scale_in = SCALE_W'(1);
    end else if (in_ch.glyph_scale > SCALE_W'(MAX_SCALE)) begin
      scale_in = SCALE_W'(MAX_SCALE);
    end else begin
      scale_in = in_ch.glyph_scale;
    end
  end

  always_comb begin
    for (int k = 0; k < LANES; k++) begin
      merged[k*BYTE_W +: BYTE_W] = (cur_col_r[LANE_W-1:0] == LANE_W'(k)) ? row_byte
                                                                        : rd_word[k*BYTE_W +: BYTE_W];
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cur_line_nxt  = cur_line_r;
    cur_col_nxt   = cur_col_r;
    bits_nxt      = bits_r;
    scale_nxt     = scale_r;
    last_nxt      = last_r;
    h_nxt         = h_r;
    gap_left_nxt  = gap_left_r;
    in_gap_nxt    = in_gap_r;
    exact_nxt     = exact_r;
    placed_nxt    = placed_r;
    word_nxt      = word_r;
    wr_addr_nxt   = wr_addr_r;
    clr_addr_nxt  = clr_addr_r;
    out_valid_nxt = out_valid_r;
    out_load      = 1'b0;
    advance       = 1'b0;
    mem_req.we    = 1'b0;
    mem_req.waddr = wr_addr_r;
    mem_req.wdata = merged;
    mem_req.re    = 1'b0;
    mem_req.raddr = idx_full[ADDR_W-1:0];

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_CLEAR: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = clr_addr_r;
        mem_req.wdata = '0;
        clr_addr_nxt  = clr_addr_r + ADDR_W'(1);
        if (clr_addr_r == ADDR_W'(BUF_DEPTH - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_ch.valid) begin
          exact_nxt  = 1'b0;
          placed_nxt = 1'b0;
          word_nxt   = '0;
          state_nxt  = ST_FINISH;
          unique case (action_t'(in_ch.action))
            ACT_SET_CURSOR: begin
              cur_line_nxt = (in_ch.line_request < REQ_W'(dims.lines))
                           ? in_ch.line_request[LINE_W-1:0]
                           : LINE_W'(dims.lines - LINES_W'(1));
              cur_col_nxt  = (in_ch.column_request < dims.cols)
                           ? in_ch.column_request : dims.cols - COL_W'(1);
              exact_nxt    = (in_ch.line_request < REQ_W'(dims.lines))
                           && (in_ch.column_request < dims.cols);
            end
            ACT_GLYPH_COL: begin
              bits_nxt   = in_ch.column_bits;
              scale_nxt  = scale_in;
              last_nxt   = in_ch.last_column;
              h_nxt      = '0;
              in_gap_nxt = 1'b0;
              placed_nxt = 1'b1;
              if (LINES_W'(cur_line_r) < dims.lines && cur_col_r < dims.cols) begin
                state_nxt = ST_ROW_RD;
              end else begin
                placed_nxt = 1'b0;
              end
            end
            ACT_READ_WORD: begin
              mem_req.re    = 1'b1;
              mem_req.raddr = in_ch.read_index;
              state_nxt     = ST_RD_WAIT;
            end
            ACT_NONE: begin
              state_nxt = ST_FINISH;
            end
            default: state_nxt = ST_FINISH;
          endcase
        end
      end
      ST_ROW_RD: begin
        if (row_in) begin
          mem_req.re  = 1'b1;
          wr_addr_nxt = idx_full[ADDR_W-1:0];
          state_nxt   = ST_ROW_WR;
        end else begin
          if (!in_gap_r) begin
            placed_nxt = 1'b0;
          end
          advance = 1'b1;
        end
      end
      ST_ROW_WR: begin
        mem_req.we = 1'b1;
        advance    = 1'b1;
      end
      ST_RD_WAIT: begin
        word_nxt  = rd_word;
        state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        if (!out_valid_r || out_ch.ready) begin
          out_load      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase

    if (advance) begin
      if (!row_last) begin
        h_nxt     = h_r + ROW_W'(1);
        state_nxt = ST_ROW_RD;
      end else begin
        cur_col_nxt = col_plus;
        if (gaps_avail != '0 && col_plus < dims.cols) begin
          in_gap_nxt   = 1'b1;
          gap_left_nxt = gaps_avail - SCALE_W'(1);
          h_nxt        = '0;
          bits_nxt     = '0;
          state_nxt    = ST_ROW_RD;
        end else begin
          state_nxt = ST_FINISH;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      cur_line_r  <= '0;
      cur_col_r   <= '0;
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cur_line_r  <= cur_line_nxt;
      cur_col_r   <= cur_col_nxt;
      clr_addr_r  <= clr_addr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bits_r     <= bits_nxt;
    scale_r    <= scale_nxt;
    last_r     <= last_nxt;
    h_r        <= h_nxt;
    gap_left_r <= gap_left_nxt;
    in_gap_r   <= in_gap_nxt;
    exact_r    <= exact_nxt;
    placed_r   <= placed_nxt;
    word_r     <= word_nxt;
    wr_addr_r  <= wr_addr_nxt;
    if (out_load) begin
      out_exact_r  <= exact_r;
      out_placed_r <= placed_r;
      out_word_r   <= word_r;
      out_line_r   <= cur_line_r;
      out_col_r    <= cur_col_r;
    end
  end

  assign in_ch.ready           = state_r == ST_IDLE;
  assign out_ch.valid          = out_valid_r;
  assign out_ch.cursor_exact   = out_exact_r;
  assign out_ch.column_placed  = out_placed_r;
  assign out_ch.read_word      = out_word_r;
  assign out_ch.current_line   = out_line_r;
  assign out_ch.current_column = out_col_r;

  a_write_follows_read: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_req.we && state_r != ST_CLEAR) |-> $past(state_r) == ST_ROW_RD)
    else $error("buffer write without a preceding read");

  a_line_stable_in_item: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE && $past(state_r) != ST_IDLE) |-> $stable(cur_line_r))
    else $error("cursor line moved during an item");

  a_result_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ST_FINISH)
    else $error("result raised outside finish");

  a_row_within_scale: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ROW_RD || state_r == ST_ROW_WR) |-> SCALE_W'(h_r) < scale_r)
    else $error("row counter beyond scale");

  a_write_inside_display: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ROW_WR) |-> $past(row_in) && cur_col_r < dims.cols)
    else $error("write outside the display");

endmodule

>>> rtl/core/scaled_glyph_column_writer_top.sv
// Reset is synchronous: cursor to zero, geometry to 128 columns and 8 lines, then a
// clearing pass zeroes the 256 buffer words with the input held off.
// A set cursor or action 3 goes from acceptance to the finish state; a read first waits
// for the registered RAM data. A glyph column does a row read-modify-write on the frame
// buffer RAM for each row inside the display and skips each row below it, over the
// column and each gap column. One item is in flight at a time; a held result stalls the next.
module scaled_glyph_column_writer_top import scgw_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  scgw_in_if.sink               in_ch,
  scgw_out_if.source            out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  dims_t             dims;
  mem_req_t          mem_req;
  logic [WORD_W-1:0] mem_rdata;

  scgw_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .dims      (dims)
  );

  scgw_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .dims      (dims),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .mem_req   (mem_req),
    .mem_rdata (mem_rdata)
  );

  scgw_ram #(
    .WIDTH (WORD_W),
    .DEPTH (BUF_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (mem_req.we),
    .waddr (mem_req.waddr),
    .wdata (mem_req.wdata),
    .re    (mem_req.re),
    .raddr (mem_req.raddr),
    .rdata (mem_rdata)
  );

endmodule
